[rtl/direction_to_yaw_pitch_defines.svh]
// Assertion macros shared by the checker of the direction to yaw/pitch block.
// Depends on i_clk and i_rst_n being visible where a macro is used.
`ifndef DIRECTION_TO_YAW_PITCH_DEFINES_SVH
`define DIRECTION_TO_YAW_PITCH_DEFINES_SVH

// Clocked property, ignored while reset is held.
`define DTYP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Implication form of the above.
`define DTYP_ASSERT_IMP(lbl, ante, cons, msg) \
    `DTYP_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

[rtl/dtyp_pkg.sv]
// Package for the direction to yaw/pitch block: widths, constants, CORDIC table.
// No dependencies.
`timescale 1ns / 1ps
package dtyp_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 18;
    localparam int COORD_W      = 32;
    localparam int ANG_OUT_W    = 9 + FRAC_BITS;
    localparam int GUARD_BITS   = 16;
    localparam int DP_W         = 52;
    localparam int ANG_W        = 42;
    localparam int RND_SH       = 32 - FRAC_BITS;
    localparam int LATENCY      = 2 * CORDIC_STEPS + 5;

    localparam logic [29:0] GAIN_INV_Q30 = 30'd652032874;
    localparam logic [63:0] PI_Q60       = 64'h3243F6A8885A308D;

    localparam logic [ANG_OUT_W-1:0] DEG360_OUT = ANG_OUT_W'(360) << FRAC_BITS;
    localparam logic [ANG_OUT_W-1:0] DEG270_OUT = ANG_OUT_W'(270) << FRAC_BITS;
    localparam logic [ANG_OUT_W-1:0] DEG90_OUT  = ANG_OUT_W'(90) << FRAC_BITS;

    typedef logic signed [DP_W-1:0]  t_dp;
    typedef logic signed [ANG_W-1:0] t_ang;

    localparam t_ang DEG180_Q32 = t_ang'(180) <<< 32;
    localparam t_ang DEG360_Q32 = t_ang'(360) <<< 32;

    function automatic logic [127:0] udiv(input logic [127:0] num, input logic [63:0] den);
        logic [64:0]  rem;
        logic [127:0] q;
        rem = '0;
        q   = '0;
        for (int b = 127; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in degrees, Q.32, from a Q60 series
    function automatic t_ang atan_deg(input int i);
        logic [63:0]  a;
        logic [63:0]  n;
        logic [63:0]  term;
        logic [127:0] q;
        int           e;
        a = '0;
        if (i == 0) begin
            return t_ang'(45) <<< 32;
        end
        for (int k = 0; k < 31; k++) begin
            e = 60 - i * (2 * k + 1);
            if (e >= 0) begin
                q    = udiv(128'(1) << e, 64'(2 * k + 1));
                term = q[63:0];
                if (k % 2 == 1) begin
                    a = a - term;
                end else begin
                    a = a + term;
                end
            end
        end
        n = (a >> 4) * 64'd180;
        q = udiv({32'd0, n, 32'd0}, PI_Q60 >> 4);
        return t_ang'(q[ANG_W-1:0]);
    endfunction

    // wrap into [0,360) and add the rounding half
    function automatic logic [ANG_W-1:0] wrap_round(input t_ang t);
        t_ang w;
        w = (t < 0) ? t + DEG360_Q32 : t;
        return (ANG_W'(w) + (ANG_W'(1) << (RND_SH - 1))) >> RND_SH;
    endfunction

endpackage

[rtl/direction_to_yaw_pitch.sv]
// Top level: pipelined vector to yaw/pitch conversion with two unrolled CORDICs.
// Depends on dtyp_pkg.
`timescale 1ns / 1ps
// One request may be issued every cycle; busy never rises. Each result appears
// for one cycle with o_valid, in request order, after it has passed the prepare
// stage, the two CORDIC pipelines (one iteration per stage) and the gain
// multiply, gain sum, round and output stages, each of which is registered.
// Results cannot be held off and are not buffered.
module direction_to_yaw_pitch (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    input  logic signed [dtyp_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [dtyp_pkg::COORD_W-1:0] i_coord_y,
    input  logic signed [dtyp_pkg::COORD_W-1:0] i_coord_z,
    output logic                               busy,
    output logic                               o_valid,
    output logic [dtyp_pkg::ANG_OUT_W-1:0]     o_yaw_deg,
    output logic [dtyp_pkg::ANG_OUT_W-1:0]     o_pitch_deg
);
    import dtyp_pkg::*;

    logic                      r_yv   [0:CORDIC_STEPS];
    t_dp                       r_yx   [0:CORDIC_STEPS];
    t_dp                       r_yy   [0:CORDIC_STEPS];
    t_ang                      r_ya   [0:CORDIC_STEPS];
    logic signed [COORD_W-1:0] r_yz   [0:CORDIC_STEPS];
    logic                      r_yzr  [0:CORDIC_STEPS];

    logic                      r_pv   [0:CORDIC_STEPS];
    t_dp                       r_px   [0:CORDIC_STEPS];
    t_dp                       r_py   [0:CORDIC_STEPS];
    t_ang                      r_pa   [0:CORDIC_STEPS];
    t_ang                      r_pyaw [0:CORDIC_STEPS];
    logic                      r_pzr  [0:CORDIC_STEPS];
    logic                      r_pzp  [0:CORDIC_STEPS];

    logic                      r_mv;
    logic [61:0]               r_mhi;
    logic [49:0]               r_mlo;
    t_ang                      r_mya;
    logic signed [COORD_W-1:0] r_mz;
    logic                      r_mzr;

    logic                      r_rv;
    logic [ANG_W-1:0]          r_ry;
    logic [ANG_W-1:0]          r_rp;
    logic                      r_rzr;
    logic                      r_rzp;

    logic                      r_ov;
    logic [ANG_OUT_W-1:0]      r_oyaw;
    logic [ANG_OUT_W-1:0]      r_opitch;

    t_dp                       n_x0;
    t_dp                       n_y0;
    logic [ANG_OUT_W-1:0]      n_oyaw;
    logic [ANG_OUT_W-1:0]      n_opitch;

    assign busy        = 1'b0;
    assign o_valid     = r_ov;
    assign o_yaw_deg   = r_oyaw;
    assign o_pitch_deg = r_opitch;

    assign n_x0 = t_dp'(i_coord_x) <<< GUARD_BITS;
    assign n_y0 = t_dp'(i_coord_y) <<< GUARD_BITS;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yv[0] <= 1'b0;
            r_mv    <= 1'b0;
            r_pv[0] <= 1'b0;
            r_rv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_yv[0] <= start && !busy;
            r_mv    <= r_yv[CORDIC_STEPS];
            r_pv[0] <= r_mv;
            r_rv    <= r_pv[CORDIC_STEPS];
            r_ov    <= r_rv;
        end
    end

    // prepare: fold left half plane onto right
    always_ff @(posedge i_clk) begin
        r_yz[0]  <= i_coord_z;
        r_yzr[0] <= (i_coord_x == '0) && (i_coord_y == '0);
        if (i_coord_x < 0) begin
            r_yx[0] <= -n_x0;
            r_yy[0] <= -n_y0;
            r_ya[0] <= DEG180_Q32;
        end else begin
            r_yx[0] <= n_x0;
            r_yy[0] <= n_y0;
            r_ya[0] <= '0;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
        localparam t_ang TAB = atan_deg(i);
        t_dp yxs, yys, pxs, pys;

        assign yxs = r_yx[i] >>> i;
        assign yys = r_yy[i] >>> i;
        assign pxs = r_px[i] >>> i;
        assign pys = r_py[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_yv[i+1] <= 1'b0;
                r_pv[i+1] <= 1'b0;
            end else begin
                r_yv[i+1] <= r_yv[i];
                r_pv[i+1] <= r_pv[i];
            end
        end

        always_ff @(posedge i_clk) begin
            r_yz[i+1]   <= r_yz[i];
            r_yzr[i+1]  <= r_yzr[i];
            r_pyaw[i+1] <= r_pyaw[i];
            r_pzr[i+1]  <= r_pzr[i];
            r_pzp[i+1]  <= r_pzp[i];
            if (r_yy[i] >= 0) begin
                r_yx[i+1] <= r_yx[i] + yys;
                r_yy[i+1] <= r_yy[i] - yxs;
                r_ya[i+1] <= r_ya[i] + TAB;
            end else begin
                r_yx[i+1] <= r_yx[i] - yys;
                r_yy[i+1] <= r_yy[i] + yxs;
                r_ya[i+1] <= r_ya[i] - TAB;
            end
            if (r_py[i] >= 0) begin
                r_px[i+1] <= r_px[i] + pys;
                r_py[i+1] <= r_py[i] - pxs;
                r_pa[i+1] <= r_pa[i] + TAB;
            end else begin
                r_px[i+1] <= r_px[i] - pys;
                r_py[i+1] <= r_py[i] + pxs;
                r_pa[i+1] <= r_pa[i] - TAB;
            end
        end
    end

    // scale magnitude by inverse CORDIC gain
    always_ff @(posedge i_clk) begin
        r_mhi <= 62'(r_yx[CORDIC_STEPS][DP_W-1:20]) * 62'(GAIN_INV_Q30);
        r_mlo <= 50'(r_yx[CORDIC_STEPS][19:0]) * 50'(GAIN_INV_Q30);
        r_mya <= r_ya[CORDIC_STEPS];
        r_mz  <= r_yz[CORDIC_STEPS];
        r_mzr <= r_yzr[CORDIC_STEPS];
    end

    always_ff @(posedge i_clk) begin
        r_px[0]   <= t_dp'(r_mhi >> 10) + t_dp'(r_mlo >> 30);
        r_py[0]   <= -(t_dp'(r_mz) <<< GUARD_BITS);
        r_pa[0]   <= '0;
        r_pyaw[0] <= r_mya;
        r_pzr[0]  <= r_mzr;
        r_pzp[0]  <= r_mz > 0;
    end

    always_ff @(posedge i_clk) begin
        r_ry  <= wrap_round(r_pyaw[CORDIC_STEPS]);
        r_rp  <= wrap_round(r_pa[CORDIC_STEPS]);
        r_rzr <= r_pzr[CORDIC_STEPS];
        r_rzp <= r_pzp[CORDIC_STEPS];
    end

    always_comb begin
        n_oyaw   = (r_ry >= ANG_W'(DEG360_OUT)) ? ANG_OUT_W'(r_ry - ANG_W'(DEG360_OUT))
                                               : ANG_OUT_W'(r_ry);
        n_opitch = (r_rp >= ANG_W'(DEG360_OUT)) ? ANG_OUT_W'(r_rp - ANG_W'(DEG360_OUT))
                                               : ANG_OUT_W'(r_rp);
        if (r_rzr) begin
            n_oyaw   = '0;
            n_opitch = r_rzp ? DEG270_OUT : DEG90_OUT;
        end
    end

    always_ff @(posedge i_clk) begin
        r_oyaw   <= n_oyaw;
        r_opitch <= n_opitch;
    end

endmodule

[rtl/dtyp_checker.sv]
// Port-level checker for the direction to yaw/pitch block, bound to its top level.
// Depends on dtyp_pkg and direction_to_yaw_pitch_defines.svh.
`timescale 1ns / 1ps
`include "direction_to_yaw_pitch_defines.svh"
module dtyp_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic signed [dtyp_pkg::COORD_W-1:0] i_coord_x,
    input logic signed [dtyp_pkg::COORD_W-1:0] i_coord_y,
    input logic signed [dtyp_pkg::COORD_W-1:0] i_coord_z,
    input logic                               busy,
    input logic                               o_valid,
    input logic [dtyp_pkg::ANG_OUT_W-1:0]     o_yaw_deg,
    input logic [dtyp_pkg::ANG_OUT_W-1:0]     o_pitch_deg
);
    import dtyp_pkg::*;

    logic req;
    logic zero_req;
    logic yaw_ok;
    logic pitch_ok;

    assign req      = start && !busy;
    assign zero_req = req && (i_coord_x == '0) && (i_coord_y == '0);
    assign yaw_ok   = o_yaw_deg < DEG360_OUT;
    assign pitch_ok = o_pitch_deg < DEG360_OUT;

    `DTYP_ASSERT_IMP(a_req_gives_result, req, ##LATENCY o_valid, "request lost")
    `DTYP_ASSERT_IMP(a_no_spurious, !req, ##LATENCY !o_valid, "result invented")
    `DTYP_ASSERT_IMP(a_range, o_valid, yaw_ok && pitch_ok, "angle out of range")
    `DTYP_ASSERT_IMP(a_zero_vec, zero_req, ##LATENCY (o_yaw_deg == '0), "zero vector yaw")
    `DTYP_ASSERT_IMP(a_zero_up, zero_req && (i_coord_z > 0), ##LATENCY (o_pitch_deg == DEG270_OUT), "zero vector pitch")

endmodule

bind direction_to_yaw_pitch dtyp_checker u_dtyp_checker (.*);
